// File: rtl/pri_pkg.sv
package pri_pkg;

    // Screen geometry and fixed isometric constants (Q2.14)
    localparam int SCREEN_WIDTH  = 1920;
    localparam int SCREEN_HEIGHT = 1080;
    localparam int ISO_COS_Q14   = 14189;
    localparam int ISO_SIN_Q14   = 8192;
    localparam int Q14_SHIFT     = 14;
    localparam int Q14_ONE       = 1 << Q14_SHIFT;

    // Field widths
    localparam int IN_W   = 16;
    localparam int OUT_W  = 24;
    localparam int TRIG_W = 16;

    // Coordinate width: a scaled point fits in 26 bits and each rotation
    // can grow a coordinate by at most a factor of four.
    localparam int CW = 34;
    localparam int PW = CW + TRIG_W;   // one rotation product
    localparam int IW = PW + 6;        // sums and isometric terms
    localparam int FW = CW + 2;        // final add before saturation

    localparam int NSTAGE = 10;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_ZOOM      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ELEVATION = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROT_X     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ROT_Y     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ROT_Z     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ISO_EN    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SHIFT_X   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SHIFT_Y   = 3'd7;
    localparam int CFG_DATA_W = 32;

    localparam logic [31:0] ROT_RESET = 32'h4000_0000;

    localparam logic signed [TRIG_W-1:0] ISO_COS = TRIG_W'(ISO_COS_Q14);
    localparam logic signed [TRIG_W-1:0] ISO_SIN = TRIG_W'(ISO_SIN_Q14);

    localparam logic signed [FW-1:0] X_CENTER = FW'(SCREEN_WIDTH / 2);
    localparam logic signed [FW-1:0] Y_CENTER = FW'(SCREEN_HEIGHT / 2);
    localparam logic signed [FW-1:0] OUT_MAX  = FW'((1 << (OUT_W - 1)) - 1);
    localparam logic signed [FW-1:0] OUT_MIN  = -OUT_MAX - FW'(1);

    // Stage advance enables for a two-stage rotation slice
    typedef struct packed {
        logic prod;
        logic sum;
    } pri_adv_t;

    // Divide by 2^14, truncating toward zero
    function automatic logic signed [CW-1:0] trunc_q14(input logic signed [IW-1:0] v);
        logic signed [IW-1:0] biased;
        logic signed [IW-1:0] shifted;
        biased  = v + (v[IW-1] ? IW'(Q14_ONE - 1) : IW'(0));
        shifted = biased >>> Q14_SHIFT;
        return shifted[CW-1:0];
    endfunction

    function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [FW-1:0] v);
        logic signed [FW-1:0] c;
        c = v;
        if (v > OUT_MAX)
        begin
            c = OUT_MAX;
        end
        if (v < OUT_MIN)
        begin
            c = OUT_MIN;
        end
        return c[OUT_W-1:0];
    endfunction

endpackage

// File: rtl/pri_point_if.sv
interface pri_point_if import pri_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic signed [IN_W-1:0] px;
    logic signed [IN_W-1:0] py;
    logic signed [IN_W-1:0] pz;

    modport source (output valid, output px, output py, output pz, input ready);
    modport sink   (input valid, input px, input py, input pz, output ready);
endinterface

// File: rtl/pri_screen_if.sv
interface pri_screen_if import pri_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] screen_x;
    logic signed [OUT_W-1:0] screen_y;

    modport source (output valid, output screen_x, output screen_y, input ready);
    modport sink   (input valid, input screen_x, input screen_y, output ready);
endinterface

// File: rtl/pri_cfg_if.sv
interface pri_cfg_if import pri_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/point_rotate_iso_project.sv
// Channel  | Dir | Payload                 | Accepted when
// ---------+-----+-------------------------+-------------------------
// point    | in  | px, py, pz              | point.valid && point.ready
// screen   | out | screen_x, screen_y      | screen.valid && screen.ready
// cfg      | in  | index, data             | cfg.valid (ready always high)
//
// One item per cycle sustained while screen.ready stays high; each item passes
// 10 register stages: scale, three rotations of two stages each (multiply,
// then sum and truncate), isometric multiply, isometric truncate or
// parallel-view pass-through, centre and offset add with saturation. rst_n
// clears the stage valid bits and loads the register defaults. A stalled
// stage holds its item; point.ready drops only when every stage holds an
// item and the output is not taken.
module point_rotate_iso_project import pri_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    pri_point_if.sink    point,
    pri_screen_if.source screen,
    pri_cfg_if.sink      cfg
);

    // Configuration registers
    logic [9:0]        zoom_reg;
    logic signed [8:0] elevation_reg;
    logic [31:0]       rot_x_reg;
    logic [31:0]       rot_y_reg;
    logic [31:0]       rot_z_reg;
    logic              iso_en_reg;
    logic signed [15:0] shift_x_reg;
    logic signed [15:0] shift_y_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zoom_reg      <= 10'd1;
            elevation_reg <= 9'sd1;
            rot_x_reg     <= ROT_RESET;
            rot_y_reg     <= ROT_RESET;
            rot_z_reg     <= ROT_RESET;
            iso_en_reg    <= 1'b1;
            shift_x_reg   <= '0;
            shift_y_reg   <= '0;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_ZOOM:      zoom_reg      <= cfg.data[9:0];
                REG_ELEVATION: elevation_reg <= cfg.data[8:0];
                REG_ROT_X:     rot_x_reg     <= cfg.data[31:0];
                REG_ROT_Y:     rot_y_reg     <= cfg.data[31:0];
                REG_ROT_Z:     rot_z_reg     <= cfg.data[31:0];
                REG_ISO_EN:    iso_en_reg    <= cfg.data[0];
                REG_SHIFT_X:   shift_x_reg   <= cfg.data[15:0];
                REG_SHIFT_Y:   shift_y_reg   <= cfg.data[15:0];
                default:       ;
            endcase
        end
    end

    // Pipeline control
    logic [NSTAGE-1:0] valid_reg;
    logic [NSTAGE-1:0] adv;

    always_comb
    begin
        adv[NSTAGE-1] = !valid_reg[NSTAGE-1] || screen.ready;
        for (int i = NSTAGE - 2; i >= 0; i--)
        begin
            adv[i] = !valid_reg[i] || adv[i+1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (adv[0])
            begin
                valid_reg[0] <= point.valid;
            end
            for (int i = 1; i < NSTAGE; i++)
            begin
                if (adv[i])
                begin
                    valid_reg[i] <= valid_reg[i-1];
                end
            end
        end
    end

    assign point.ready  = adv[0];
    assign screen.valid = valid_reg[NSTAGE-1];

    // Stage 0: scale
    logic signed [CW-1:0] sx_reg;
    logic signed [CW-1:0] sy_reg;
    logic signed [CW-1:0] sz_reg;
    logic signed [CW-1:0] sx_next;
    logic signed [CW-1:0] sy_next;
    logic signed [CW-1:0] sz_next;
    logic signed [10:0]   zoom_s;

    assign zoom_s  = {1'b0, zoom_reg};
    assign sx_next = point.px * zoom_s;
    assign sy_next = point.py * zoom_s;
    assign sz_next = point.pz * elevation_reg;

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            sx_reg <= sx_next;
            sy_reg <= sy_next;
            sz_reg <= sz_next;
        end
    end

    // Stages 1..6: rotations about x, y, z
    logic signed [CW-1:0] rx_x;
    logic signed [CW-1:0] rx_y;
    logic signed [CW-1:0] rx_z;
    logic signed [CW-1:0] ry_x;
    logic signed [CW-1:0] ry_y;
    logic signed [CW-1:0] ry_z;
    logic signed [CW-1:0] rz_x;
    logic signed [CW-1:0] rz_y;
    logic signed [CW-1:0] rz_z;

    pri_rotate u_rot_x (
        .clk      (clk),
        .adv      ('{prod: adv[1], sum: adv[2]}),
        .cos_sin  (rot_x_reg),
        .u_in     (sy_reg),
        .v_in     (sz_reg),
        .pass_in  (sx_reg),
        .u_out    (rx_y),
        .v_out    (rx_z),
        .pass_out (rx_x)
    );

    pri_rotate u_rot_y (
        .clk      (clk),
        .adv      ('{prod: adv[3], sum: adv[4]}),
        .cos_sin  (rot_y_reg),
        .u_in     (rx_z),
        .v_in     (rx_x),
        .pass_in  (rx_y),
        .u_out    (ry_z),
        .v_out    (ry_x),
        .pass_out (ry_y)
    );

    pri_rotate u_rot_z (
        .clk      (clk),
        .adv      ('{prod: adv[5], sum: adv[6]}),
        .cos_sin  (rot_z_reg),
        .u_in     (ry_x),
        .v_in     (ry_y),
        .pass_in  (ry_z),
        .u_out    (rz_x),
        .v_out    (rz_y),
        .pass_out (rz_z)
    );

    // Stage 7: isometric products
    logic signed [IW-1:0] iso_a_reg;
    logic signed [IW-1:0] iso_b_reg;
    logic signed [CW-1:0] iso_z_reg;
    logic signed [CW-1:0] iso_x_reg;
    logic signed [CW-1:0] iso_y_reg;
    logic signed [CW:0]   iso_diff;
    logic signed [CW:0]   iso_sum;
    logic signed [IW-1:0] iso_a_next;
    logic signed [IW-1:0] iso_b_next;

    assign iso_diff   = (CW+1)'(rz_x) - (CW+1)'(rz_y);
    assign iso_sum    = (CW+1)'(rz_x) + (CW+1)'(rz_y);
    assign iso_a_next = iso_diff * ISO_COS;
    assign iso_b_next = iso_sum * ISO_SIN;

    always_ff @(posedge clk)
    begin
        if (adv[7])
        begin
            iso_a_reg <= iso_a_next;
            iso_b_reg <= iso_b_next;
            iso_z_reg <= rz_z;
            iso_x_reg <= rz_x;
            iso_y_reg <= rz_y;
        end
    end

    // Stage 8: isometric truncate or parallel view
    logic signed [CW-1:0] px9_reg;
    logic signed [CW-1:0] py9_reg;
    logic signed [CW-1:0] px9_next;
    logic signed [CW-1:0] py9_next;
    logic signed [IW-1:0] z_q14;

    assign z_q14 = IW'(iso_z_reg) <<< Q14_SHIFT;

    always_comb
    begin
        if (iso_en_reg)
        begin
            px9_next = trunc_q14(iso_a_reg);
            py9_next = trunc_q14(iso_b_reg - z_q14);
        end
        else
        begin
            px9_next = iso_x_reg;
            py9_next = iso_y_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[8])
        begin
            px9_reg <= px9_next;
            py9_reg <= py9_next;
        end
    end

    // Stage 9: center, offset, saturate into the output register
    logic signed [OUT_W-1:0] screen_x_reg;
    logic signed [OUT_W-1:0] screen_y_reg;
    logic signed [FW-1:0]    fx;
    logic signed [FW-1:0]    fy;

    assign fx = FW'(px9_reg) + X_CENTER + FW'(shift_x_reg);
    assign fy = FW'(py9_reg) + Y_CENTER + FW'(shift_y_reg);

    always_ff @(posedge clk)
    begin
        if (adv[9])
        begin
            screen_x_reg <= sat_out(fx);
            screen_y_reg <= sat_out(fy);
        end
    end

    assign screen.screen_x = screen_x_reg;
    assign screen.screen_y = screen_y_reg;

    // The held stage before the output keeps its item
    a_stall_keeps: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg[NSTAGE-2] && !adv[NSTAGE-2]) |=> valid_reg[NSTAGE-2])
        else $error("stalled stage dropped its item");

    // Input backpressure only when the whole pipeline is full
    a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
        !point.ready |-> (&valid_reg))
        else $error("input stalled with a free stage");

    // A new result comes only from the stage before the output
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(screen.valid) |-> $past(valid_reg[NSTAGE-2]))
        else $error("result appeared without a feeding item");

    // First stage captures exactly the accepted item
    a_first_stage: assert property (@(posedge clk) disable iff (!rst_n)
        (point.valid && point.ready) |=> valid_reg[0])
        else $error("accepted item not captured");

endmodule

// File: rtl/pri_rotate.sv
// One plane rotation: (u, v) <- (u*c - v*s, u*s + v*c) / 2^14.
// Products are registered, then summed and truncated in the next stage.
module pri_rotate import pri_pkg::*; (
    input  logic                 clk,
    input  pri_adv_t             adv,
    input  logic [31:0]          cos_sin,
    input  logic signed [CW-1:0] u_in,
    input  logic signed [CW-1:0] v_in,
    input  logic signed [CW-1:0] pass_in,
    output logic signed [CW-1:0] u_out,
    output logic signed [CW-1:0] v_out,
    output logic signed [CW-1:0] pass_out
);

    logic signed [TRIG_W-1:0] c;
    logic signed [TRIG_W-1:0] s;

    logic signed [PW-1:0] uc_reg;
    logic signed [PW-1:0] vs_reg;
    logic signed [PW-1:0] us_reg;
    logic signed [PW-1:0] vc_reg;
    logic signed [CW-1:0] pass_p_reg;

    logic signed [CW-1:0] u_reg;
    logic signed [CW-1:0] v_reg;
    logic signed [CW-1:0] pass_reg;

    logic signed [CW-1:0] u_next;
    logic signed [CW-1:0] v_next;

    assign c = cos_sin[31:16];
    assign s = cos_sin[15:0];

    assign u_next = trunc_q14(IW'(uc_reg) - IW'(vs_reg));
    assign v_next = trunc_q14(IW'(us_reg) + IW'(vc_reg));

    always_ff @(posedge clk)
    begin
        if (adv.prod)
        begin
            uc_reg     <= u_in * c;
            vs_reg     <= v_in * s;
            us_reg     <= u_in * s;
            vc_reg     <= v_in * c;
            pass_p_reg <= pass_in;
        end
        if (adv.sum)
        begin
            u_reg    <= u_next;
            v_reg    <= v_next;
            pass_reg <= pass_p_reg;
        end
    end

    assign u_out    = u_reg;
    assign v_out    = v_reg;
    assign pass_out = pass_reg;

endmodule

// File: tb/sv/tb_top.sv
module tb_top;
    import pri_pkg::*;

    typedef enum logic [1:0] {OP_POINT, OP_CFG, OP_DRAIN} feed_kind_e;

    typedef struct {
        feed_kind_e             kind;
        logic signed [IN_W-1:0] px;
        logic signed [IN_W-1:0] py;
        logic signed [IN_W-1:0] pz;
        logic [CFG_IDX_W-1:0]   idx;
        logic [CFG_DATA_W-1:0]  data;
        bit                     calm;
    } feed_t;

    typedef struct {
        logic signed [OUT_W-1:0] sx;
        logic signed [OUT_W-1:0] sy;
    } screen_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    pri_point_if  point_if ();
    pri_screen_if screen_if ();
    pri_cfg_if    cfg_if ();

    point_rotate_iso_project u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .point  (point_if),
        .screen (screen_if),
        .cfg    (cfg_if)
    );

    // register copies used by the predictor
    logic [9:0]              zoom_m;
    logic signed [8:0]       elev_m;
    logic [31:0]             rot_m [3];
    logic                    iso_m;
    logic signed [IN_W-1:0]  shx_m;
    logic signed [IN_W-1:0]  shy_m;

    feed_t   vertex_feed_q [$];
    screen_t screen_due_q [$];

    int  sent_cnt    = 0;
    int  seen_cnt    = 0;
    int  err_cnt     = 0;
    int  setting_cnt = 0;
    int  flat_cnt    = 0;
    bit  calm_now    = 1'b0;
    bit  fill_calm   = 1'b0;

    logic [CFG_IDX_W-1:0] all_regs [8] = '{REG_ZOOM, REG_ELEVATION, REG_ROT_X, REG_ROT_Y,
                                           REG_ROT_Z, REG_ISO_EN, REG_SHIFT_X, REG_SHIFT_Y};

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // (u, v) <- (u*c - v*s, u*s + v*c) / 2^14, truncated toward zero
    function automatic void rotate_q14(inout longint u, inout longint v, input logic [31:0] cs);
        longint c;
        longint s;
        longint a;
        longint b;
        c = longint'($signed(cs[31:16]));
        s = longint'($signed(cs[15:0]));
        a = u;
        b = v;
        u = (a * c - b * s) / Q14_ONE;
        v = (a * s + b * c) / Q14_ONE;
    endfunction

    function automatic logic signed [OUT_W-1:0] clamp_screen(longint v);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (OUT_W - 1)) - 1;
        lo = -hi - 1;
        if (v > hi)
        begin
            v = hi;
        end
        if (v < lo)
        begin
            v = lo;
        end
        return v[OUT_W-1:0];
    endfunction

    function automatic screen_t project_vertex(logic signed [IN_W-1:0] vx,
                                               logic signed [IN_W-1:0] vy,
                                               logic signed [IN_W-1:0] vz);
        longint  x;
        longint  y;
        longint  z;
        longint  ox;
        screen_t r;
        x = longint'(vx) * longint'(zoom_m);
        y = longint'(vy) * longint'(zoom_m);
        z = longint'(vz) * longint'(elev_m);
        // x axis turns (y, z), y axis turns (z, x), z axis turns (x, y)
        rotate_q14(y, z, rot_m[0]);
        rotate_q14(z, x, rot_m[1]);
        rotate_q14(x, y, rot_m[2]);
        if (iso_m)
        begin
            ox = x;
            x = ((ox - y) * ISO_COS_Q14) / Q14_ONE;
            y = ((ox + y) * ISO_SIN_Q14 - z * Q14_ONE) / Q14_ONE;
        end
        x += SCREEN_WIDTH / 2 + longint'(shx_m);
        y += SCREEN_HEIGHT / 2 + longint'(shy_m);
        r.sx = clamp_screen(x);
        r.sy = clamp_screen(y);
        return r;
    endfunction

    function automatic bit take_gap();
        return !calm_now && ($urandom_range(99) < 32);
    endfunction

    function automatic logic signed [IN_W-1:0] pick_coord();
        logic signed [IN_W-1:0] corner_vals [6] = '{IN_W'(-32768), IN_W'(-32767), IN_W'(-1),
                                                   IN_W'(0), IN_W'(1), IN_W'(32767)};
        int sel;
        sel = $urandom_range(99);
        if (sel < 60)
        begin
            return IN_W'($urandom_range(255) - 128);
        end
        else if (sel < 85)
        begin
            return IN_W'($urandom());
        end
        return corner_vals[$urandom_range(5)];
    endfunction

    // upper data bits stay random so that the register masking gets exercised
    function automatic logic [CFG_DATA_W-1:0] pick_setting(logic [CFG_IDX_W-1:0] r);
        int sel;
        logic [CFG_DATA_W-1:0] v;
        sel = $urandom_range(9);
        v = $urandom();
        case (r)
            REG_ZOOM:
            begin
                if (sel < 5)
                    v[9:0] = 10'($urandom_range(40, 1));
                else if (sel == 7)
                    v[9:0] = 10'd0;
                else if (sel == 8)
                    v[9:0] = 10'd1023;
                else if (sel == 9)
                    v[9:0] = 10'd1;
            end
            REG_ELEVATION:
            begin
                if (sel < 5)
                    v[8:0] = 9'($urandom_range(40) - 20);
                else if (sel == 7)
                    v[8:0] = 9'h101;
                else if (sel == 8)
                    v[8:0] = 9'h0FF;
                else if (sel == 9)
                    v[8:0] = 9'h000;
            end
            REG_ROT_X, REG_ROT_Y, REG_ROT_Z:
            begin
                if (sel < 4)
                    v = {16'(16384 - $urandom_range(3000)), 16'($urandom_range(16000) - 8000)};
                else if (sel == 6)
                    v = ROT_RESET;
                else if (sel == 7)
                    v = 32'h7FFF_8000;
                else if (sel == 8)
                    v = 32'h8000_7FFF;
                else if (sel == 9)
                    v = 32'hC000_0000;
            end
            REG_SHIFT_X, REG_SHIFT_Y:
            begin
                if (sel < 6)
                    v[15:0] = 16'($urandom_range(400) - 200);
                else if (sel == 8)
                    v[15:0] = 16'h8000;
                else if (sel == 9)
                    v[15:0] = 16'h7FFF;
            end
            default:
            begin
            end
        endcase
        return v;
    endfunction

    task automatic add_point(logic signed [IN_W-1:0] x, logic signed [IN_W-1:0] y,
                             logic signed [IN_W-1:0] z);
        feed_t f;
        f = '{kind: OP_POINT, px: x, py: y, pz: z, idx: '0, data: '0, calm: fill_calm};
        vertex_feed_q.push_back(f);
    endtask

    task automatic add_write(logic [CFG_IDX_W-1:0] r, logic [CFG_DATA_W-1:0] d);
        feed_t f;
        f = '{kind: OP_CFG, px: '0, py: '0, pz: '0, idx: r, data: d, calm: 1'b0};
        vertex_feed_q.push_back(f);
    endtask

    task automatic add_pause();
        feed_t f;
        f = '{kind: OP_DRAIN, px: '0, py: '0, pz: '0, idx: '0, data: '0, calm: 1'b0};
        vertex_feed_q.push_back(f);
    endtask

    task automatic report_error(string msg);
        err_cnt++;
        if (err_cnt <= 10)
        begin
            $display("ERROR: %s", msg);
        end
    endtask

    // driver: register writes and pauses wait until every result is back
    always @(posedge clk)
    begin
        feed_t head;
        bit    pt_hold;
        bit    cf_hold;
        bit    pv;
        bit    cv;
        if (rst_n)
        begin
            pt_hold = point_if.valid && !point_if.ready;
            cf_hold = cfg_if.valid && !cfg_if.ready;
            if (point_if.valid && point_if.ready)
            begin
                sent_cnt++;
            end
            pv = pt_hold;
            cv = cf_hold;
            if (!pt_hold && !cf_hold && vertex_feed_q.size() > 0)
            begin
                head = vertex_feed_q[0];
                case (head.kind)
                    OP_POINT:
                    begin
                        if (!take_gap())
                        begin
                            pv = 1'b1;
                            point_if.px <= head.px;
                            point_if.py <= head.py;
                            point_if.pz <= head.pz;
                            calm_now    <= head.calm;
                            void'(vertex_feed_q.pop_front());
                        end
                    end
                    OP_CFG:
                    begin
                        if (sent_cnt == seen_cnt)
                        begin
                            cv = 1'b1;
                            cfg_if.index <= head.idx;
                            cfg_if.data  <= head.data;
                            void'(vertex_feed_q.pop_front());
                        end
                    end
                    default:
                    begin
                        if (sent_cnt == seen_cnt)
                        begin
                            void'(vertex_feed_q.pop_front());
                        end
                    end
                endcase
            end
            point_if.valid <= pv;
            cfg_if.valid   <= cv;
        end
    end

    // monitor: checks results first, then tracks writes and accepted vertices
    always @(posedge clk)
    begin
        screen_t want;
        if (!rst_n)
        begin
            zoom_m   = 10'd1;
            elev_m   = 9'sd1;
            rot_m[0] = ROT_RESET;
            rot_m[1] = ROT_RESET;
            rot_m[2] = ROT_RESET;
            iso_m    = 1'b1;
            shx_m    = '0;
            shy_m    = '0;
            screen_if.ready <= 1'b0;
        end
        else
        begin
            if (screen_if.valid && screen_if.ready)
            begin
                seen_cnt++;
                if (screen_due_q.size() == 0)
                begin
                    report_error($sformatf("unexpected item x=%0d y=%0d",
                                           screen_if.screen_x, screen_if.screen_y));
                end
                else
                begin
                    want = screen_due_q.pop_front();
                    if (want.sx !== screen_if.screen_x || want.sy !== screen_if.screen_y)
                    begin
                        report_error($sformatf("item %0d: expected x=%0d y=%0d, got x=%0d y=%0d",
                                               seen_cnt, want.sx, want.sy,
                                               screen_if.screen_x, screen_if.screen_y));
                    end
                end
            end
            if (cfg_if.valid && cfg_if.ready)
            begin
                case (cfg_if.index)
                    REG_ZOOM:      zoom_m   = cfg_if.data[9:0];
                    REG_ELEVATION: elev_m   = cfg_if.data[8:0];
                    REG_ROT_X:     rot_m[0] = cfg_if.data;
                    REG_ROT_Y:     rot_m[1] = cfg_if.data;
                    REG_ROT_Z:     rot_m[2] = cfg_if.data;
                    REG_ISO_EN:    iso_m    = cfg_if.data[0];
                    REG_SHIFT_X:   shx_m    = cfg_if.data[15:0];
                    REG_SHIFT_Y:   shy_m    = cfg_if.data[15:0];
                    default:
                    begin
                    end
                endcase
            end
            if (point_if.valid && point_if.ready)
            begin
                screen_due_q.push_back(project_vertex(point_if.px, point_if.py, point_if.pz));
                if (!iso_m)
                begin
                    flat_cnt++;
                end
            end
            screen_if.ready <= !take_gap();
        end
    end

    initial
    begin
        point_if.valid  = 1'b0;
        point_if.px     = '0;
        point_if.py     = '0;
        point_if.pz     = '0;
        cfg_if.valid    = 1'b0;
        cfg_if.index    = REG_ZOOM;
        cfg_if.data     = '0;
        screen_if.ready = 1'b0;

        // reset settings: identity rotations, isometric view
        add_point(0, 0, 0);
        add_point(1, -1, 1);
        add_point(32767, 32767, 32767);
        add_point(-32768, -32768, -32768);
        add_point(32767, -32768, 0);
        add_point(-1, -1, -1);

        // largest zoom, elevation -255, trig magnitudes near two, offsets at the ends: saturation
        setting_cnt++;
        add_write(REG_ZOOM, 32'd1023);
        add_write(REG_ELEVATION, 32'h0000_0101);
        add_write(REG_ROT_X, 32'h7FFF_8000);
        add_write(REG_ROT_Y, 32'h8000_7FFF);
        add_write(REG_ROT_Z, 32'h7FFF_7FFF);
        add_write(REG_ISO_EN, 32'd1);
        add_write(REG_SHIFT_X, 32'h0000_8000);
        add_write(REG_SHIFT_Y, 32'h0000_7FFF);
        add_point(32767, 32767, 32767);
        add_point(-32768, -32768, -32768);
        add_point(32767, -32768, 32767);
        add_point(-32768, 32767, -32768);
        add_point(123, -456, 789);

        // zero zoom, parallel view, half, quarter and 45 degree turns
        setting_cnt++;
        add_write(REG_ZOOM, 32'd0);
        add_write(REG_ELEVATION, 32'h0000_00FF);
        add_write(REG_ISO_EN, 32'd0);
        add_write(REG_SHIFT_X, 32'h0000_7FFF);
        add_write(REG_SHIFT_Y, 32'h0000_8000);
        add_write(REG_ROT_X, 32'hC000_0000);
        add_write(REG_ROT_Y, 32'h0000_4000);
        add_write(REG_ROT_Z, 32'h2D41_2D41);
        add_point(32767, -32768, 32767);
        add_point(-32768, 32767, -32768);
        add_point(0, 0, 1);
        add_point(-7, 5, -3);

        // 45 degree turn with negative elevation: truncation of negative sums
        setting_cnt++;
        add_write(REG_ZOOM, 32'd37);
        add_write(REG_ELEVATION, 32'h0000_01FF);
        add_write(REG_ISO_EN, 32'd1);
        add_write(REG_SHIFT_X, 32'd0);
        add_write(REG_SHIFT_Y, 32'd0);
        add_point(1, 2, 3);
        add_point(-3, -2, -1);
        add_point(100, -100, 50);
        add_point(-32768, 0, 32767);
        add_point(0, -32768, 0);

        for (int ph = 0; ph < 10; ph++)
        begin
            setting_cnt++;
            foreach (all_regs[i])
            begin
                if (ph == 0 || $urandom_range(3) != 0)
                begin
                    add_write(all_regs[i], pick_setting(all_regs[i]));
                end
            end
            fill_calm = (ph == 4);
            for (int k = 0; k < 163; k++)
            begin
                // one hold-off until the pipeline is empty, mid-phase
                if (ph == 6 && k == 80)
                begin
                    add_pause();
                end
                add_point(pick_coord(), pick_coord(), pick_coord());
            end
        end

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        while (vertex_feed_q.size() != 0 || point_if.valid || sent_cnt != seen_cnt)
        begin
            @(posedge clk);
        end
        repeat (NSTAGE + 4) @(posedge clk);

        if (screen_due_q.size() != 0)
        begin
            report_error($sformatf("%0d results never arrived", screen_due_q.size()));
        end

        $display("Projected %0d vertices (%0d in parallel view) under %0d register settings,",
                 seen_cnt, flat_cnt, setting_cnt);
        $display("with random stalls on both channels; %0d mismatches found.", err_cnt);
        if (err_cnt == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial
    begin
        #2000000;
        $display("Some tests failed");
        $finish;
    end

endmodule

// File: files.f
rtl/pri_pkg.sv
rtl/pri_point_if.sv
rtl/pri_screen_if.sv
rtl/pri_cfg_if.sv
rtl/pri_rotate.sv
rtl/point_rotate_iso_project.sv
tb/sv/tb_top.sv
